>>> src/query_string_tokenizer_macros.svh
// Assertion macros used by the query string tokenizer top level.
`ifndef QUERY_STRING_TOKENIZER_MACROS_SVH
`define QUERY_STRING_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define QST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/qst_pkg.sv
// Types, codes and constants of the query string tokenizer.
`timescale 1ns / 1ps

package qst_pkg;

    localparam int OFF_W      = 10;
    localparam int IDX_W      = 4;
    localparam int PREFIX_LEN = 10;
    // a final byte at this position or below leaves the path too short
    localparam int SHORT_POS  = 7;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 4;

    localparam logic [7:0] ASCII_EQ  = 8'h3D;
    localparam logic [7:0] ASCII_AMP = 8'h26;

    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PREFIX   = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_NAME_START  = 4'b0001,
        PH_NAME        = 4'b0010,
        PH_VALUE_START = 4'b0100,
        PH_VALUE       = 4'b1000
    } phase_t;

    // One classified byte, handed from the front to the back
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic             in_prefix;
        logic             bad_prefix;
        logic             too_long;
        logic             is_eq;
        logic             is_amp;
        logic             is_last;
        logic             short_path;
    } cls_t;

    // One result item
    typedef struct packed {
        logic             kind;
        status_t          status;
        logic [IDX_W-1:0] pair_index;
        logic [OFF_W-1:0] name_offset;
        logic [OFF_W-1:0] name_length;
        logic [OFF_W-1:0] value_offset;
        logic [OFF_W-1:0] value_length;
        logic             run_end;
    } result_t;

    // Expected prefix "/ajax.cgi?"
    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h2F;
            4'd1:    b = 8'h61;
            4'd2:    b = 8'h6A;
            4'd3:    b = 8'h61;
            4'd4:    b = 8'h78;
            4'd5:    b = 8'h2E;
            4'd6:    b = 8'h63;
            4'd7:    b = 8'h67;
            4'd8:    b = 8'h69;
            4'd9:    b = 8'h3F;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> src/qst_fifo.sv
// Small register queue between the classifier and the parser.
`timescale 1ns / 1ps

module qst_fifo #(
    parameter int  DEPTH  = 4,
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  item_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output item_t rd_data,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t         mem [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rptr_reg];

    // pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/qst_front.sv
// Front end: byte position tracking and byte classification.
`timescale 1ns / 1ps

module qst_front #(
    parameter int MAX_PATH_LEN = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    char_byte,
    input  logic          is_last,
    input  logic          push,
    input  logic          q_full,
    output logic          q_wr,
    output qst_pkg::cls_t q_data
);

    import qst_pkg::*;

    localparam int POS_W = $clog2(MAX_PATH_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_PATH_LEN);
    localparam logic [POS_W-1:0] POS_PREFIX = POS_W'(PREFIX_LEN);
    localparam logic [POS_W-1:0] POS_SHORT  = POS_W'(SHORT_POS);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [OFF_W+POS_W-1:0] pos_ext;
    logic                   accept;

    assign accept  = push && !q_full;
    assign q_wr    = accept;
    assign pos_ext = {{OFF_W{1'b0}}, pos_reg};

    // classify the incoming byte against its position
    always_comb
    begin
        q_data.off        = pos_ext[OFF_W-1:0];
        q_data.in_prefix  = (pos_reg < POS_PREFIX);
        q_data.bad_prefix = (char_byte != prefix_byte(pos_reg[3:0]));
        q_data.too_long   = (pos_reg >= POS_MAX);
        q_data.is_eq      = (char_byte == ASCII_EQ);
        q_data.is_amp     = (char_byte == ASCII_AMP);
        q_data.is_last    = is_last;
        q_data.short_path = (pos_reg <= POS_SHORT);
    end

    // position saturates, restarts after the last byte of a path
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (is_last)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

>>> src/qst_back.sv
// Back end: pair splitting state machine and result buffer.
`timescale 1ns / 1ps

module qst_back #(
    parameter int MAX_PAIRS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qst_pkg::cls_t                 q_data,
    input  logic                          q_empty,
    output logic                          q_rd,
    input  logic                          pop,
    output logic                          empty,
    output logic                          kind,
    output logic [1:0]                    status,
    output logic [qst_pkg::IDX_W-1:0]     pair_index,
    output logic [qst_pkg::OFF_W-1:0]     name_offset,
    output logic [qst_pkg::OFF_W-1:0]     name_length,
    output logic [qst_pkg::OFF_W-1:0]     value_offset,
    output logic [qst_pkg::OFF_W-1:0]     value_length,
    output logic                          run_end
);

    import qst_pkg::*;

    localparam int OAW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam logic [OAW-1:0] OUT_LAST  = OAW'(OUT_DEPTH - 1);
    localparam logic [OCW-1:0] ROOM_CNT  = OCW'(OUT_DEPTH - 2);
    localparam logic [IDX_W-1:0] PAIR_LIM = IDX_W'(MAX_PAIRS);

    // parser state
    phase_t           phase_reg, phase_next;
    status_t          err_reg, err_next;
    logic [OFF_W-1:0] run_reg, run_next, run_base;
    logic [IDX_W-1:0] pair_reg, pair_next;
    logic [OFF_W-1:0] cno_reg, cno_next;
    logic [OFF_W-1:0] cnl_reg, cnl_next;
    logic [OFF_W-1:0] cvo_reg, cvo_next;

    // result buffer
    result_t          obuf [OUT_DEPTH];
    logic [OAW-1:0]   wptr_reg, wptr_next, wptr_inc, wptr_stat;
    logic [OAW-1:0]   rptr_reg, rptr_next;
    logic [OCW-1:0]   ocnt_reg, ocnt_next;
    logic             take, out_pop;
    logic             pair_v, stat_v;
    result_t          pair_res, stat_res, head;

    // take an item only with room for two results
    assign take    = !q_empty && (ocnt_reg <= ROOM_CNT);
    assign q_rd    = take;
    assign empty   = (ocnt_reg == '0);
    assign out_pop = pop && !empty;
    assign stat_v  = take && q_data.is_last;

    // pair splitting
    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        run_next   = run_reg;
        run_base   = run_reg;
        pair_next  = pair_reg;
        cno_next   = cno_reg;
        cnl_next   = cnl_reg;
        cvo_next   = cvo_reg;
        pair_v     = 1'b0;
        pair_res   = '0;
        stat_res   = '0;
        if (take)
        begin
            if (err_reg == ST_OK)
            begin
                if (q_data.too_long)
                begin
                    err_next = ST_TOO_LONG;
                end
                else if (q_data.in_prefix)
                begin
                    if (q_data.bad_prefix)
                    begin
                        err_next = ST_PREFIX;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_NAME_START:
                        begin
                            cno_next   = q_data.off;
                            cnl_next   = '0;
                            cvo_next   = '0;
                            run_base   = '0;
                            phase_next = PH_NAME;
                        end
                        PH_NAME:
                        begin
                            if (q_data.is_eq)
                            begin
                                cnl_next   = run_reg;
                                phase_next = PH_VALUE_START;
                            end
                        end
                        PH_VALUE_START:
                        begin
                            cvo_next   = q_data.off;
                            run_base   = '0;
                            phase_next = PH_VALUE;
                        end
                        PH_VALUE:
                        begin
                            if (q_data.is_amp)
                            begin
                                pair_v                = 1'b1;
                                pair_res.kind         = KIND_PAIR;
                                pair_res.status       = ST_OK;
                                pair_res.pair_index   = pair_reg;
                                pair_res.name_offset  = cno_reg;
                                pair_res.name_length  = cnl_reg;
                                pair_res.value_offset = cvo_reg;
                                pair_res.value_length = run_reg;
                                pair_res.run_end      = !q_data.is_last;
                                pair_next             = pair_reg + 1'b1;
                                phase_next            = PH_NAME_START;
                                if (pair_next == PAIR_LIM)
                                begin
                                    err_next = ST_TOO_MANY;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_NAME_START;
                        end
                    endcase
                    run_next = run_base + 1'b1;
                end
            end

            // end of path: open value, then status
            if (q_data.is_last)
            begin
                if ((err_next == ST_OK) && (phase_next == PH_VALUE) && !q_data.in_prefix)
                begin
                    pair_v                = 1'b1;
                    pair_res.kind         = KIND_PAIR;
                    pair_res.status       = ST_OK;
                    pair_res.pair_index   = pair_next;
                    pair_res.name_offset  = cno_next;
                    pair_res.name_length  = cnl_next;
                    pair_res.value_offset = cvo_next;
                    pair_res.value_length = run_next;
                    pair_res.run_end      = 1'b0;
                end
                stat_res.kind    = KIND_STATUS;
                stat_res.status  = ((err_next == ST_OK) && q_data.short_path) ?
                                   ST_PREFIX : err_next;
                stat_res.run_end = 1'b1;
                phase_next = PH_NAME_START;
                err_next   = ST_OK;
                run_next   = '0;
                pair_next  = '0;
                cno_next   = '0;
                cnl_next   = '0;
                cvo_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME_START;
            err_reg   <= ST_OK;
            run_reg   <= '0;
            pair_reg  <= '0;
            cno_reg   <= '0;
            cnl_reg   <= '0;
            cvo_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            run_reg   <= run_next;
            pair_reg  <= pair_next;
            cno_reg   <= cno_next;
            cnl_reg   <= cnl_next;
            cvo_reg   <= cvo_next;
        end
    end

    // result buffer pointers
    always_comb
    begin
        wptr_inc  = (wptr_reg == OUT_LAST) ? '0 : wptr_reg + 1'b1;
        wptr_stat = pair_v ? wptr_inc : wptr_reg;
        wptr_next = wptr_reg;
        if (stat_v)
        begin
            wptr_next = (wptr_stat == OUT_LAST) ? '0 : wptr_stat + 1'b1;
        end
        else if (pair_v)
        begin
            wptr_next = wptr_inc;
        end
        rptr_next = rptr_reg;
        if (out_pop)
        begin
            rptr_next = (rptr_reg == OUT_LAST) ? '0 : rptr_reg + 1'b1;
        end
        ocnt_next = ocnt_reg + OCW'(pair_v) + OCW'(stat_v) - OCW'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            ocnt_reg <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_v)
        begin
            obuf[wptr_reg] <= pair_res;
        end
        if (stat_v)
        begin
            obuf[wptr_stat] <= stat_res;
        end
    end

    // head of the buffer drives the result ports
    assign head         = obuf[rptr_reg];
    assign kind         = head.kind;
    assign status       = head.status;
    assign pair_index   = head.pair_index;
    assign name_offset  = head.name_offset;
    assign name_length  = head.name_length;
    assign value_offset = head.value_offset;
    assign value_length = head.value_length;
    assign run_end      = head.run_end;

endmodule

>>> src/query_string_tokenizer.sv
// An accepted byte is registered in the queue, then its results in the result buffer.
// Throughput: one byte per cycle while full is low; the result buffer drains one result
// per cycle, and the parser takes a byte only while the buffer has room for two results.
// Reset: rst_n low clears the queues, the position counter and the parser state
// at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "query_string_tokenizer_macros.svh"

module query_string_tokenizer #(
    parameter int MAX_PAIRS    = 10,
    parameter int MAX_PATH_LEN = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                char_byte,
    input  logic                      is_last,
    input  logic                      push,
    output logic                      full,
    output logic                      empty,
    input  logic                      pop,
    output logic                      kind,
    output logic [1:0]                status,
    output logic [qst_pkg::IDX_W-1:0] pair_index,
    output logic [qst_pkg::OFF_W-1:0] name_offset,
    output logic [qst_pkg::OFF_W-1:0] name_length,
    output logic [qst_pkg::OFF_W-1:0] value_offset,
    output logic [qst_pkg::OFF_W-1:0] value_length,
    output logic                      run_end
);

    import qst_pkg::*;

    cls_t front_data, back_data;
    logic mid_wr, mid_full, mid_rd, mid_empty;
    logic pair_head, stat_head;

    assign full = mid_full;

    // byte classifier
    qst_front #(
        .MAX_PATH_LEN(MAX_PATH_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_byte(char_byte),
        .is_last  (is_last),
        .push     (push),
        .q_full   (mid_full),
        .q_wr     (mid_wr),
        .q_data   (front_data)
    );

    // queue between front and back
    qst_fifo #(
        .DEPTH (MID_DEPTH),
        .item_t(cls_t)
    ) u_mid_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (mid_wr),
        .wr_data(front_data),
        .full   (mid_full),
        .rd_en  (mid_rd),
        .rd_data(back_data),
        .empty  (mid_empty)
    );

    // parser and result buffer
    qst_back #(
        .MAX_PAIRS(MAX_PAIRS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (back_data),
        .q_empty     (mid_empty),
        .q_rd        (mid_rd),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .status      (status),
        .pair_index  (pair_index),
        .name_offset (name_offset),
        .name_length (name_length),
        .value_offset(value_offset),
        .value_length(value_length),
        .run_end     (run_end)
    );

    // checks
    assign pair_head = !empty && (kind == KIND_PAIR);
    assign stat_head = !empty && (kind == KIND_STATUS);

    `QST_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !full, !mid_empty, "item lost at queue")
    `QST_ASSERT_NOW(a_pair_ok, clk, rst_n, pair_head, status == ST_OK, "pair with bad status")
    `QST_ASSERT_NOW(a_status_ends, clk, rst_n, stat_head, run_end && (pair_index == '0), "bad status")

endmodule
